[sv/dhoat_pkg.sv]
// ----------------------------------------------------------------------------
// dhoat_pkg
// Shared types and codes for the double-hash open-address table.
// ----------------------------------------------------------------------------
package dhoat_pkg;

    localparam int CMD_BITS  = 2;
    localparam int CFG_BITS  = 11;
    localparam int SLOT_BITS = 10;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_USED  = 2'd1,
        MARK_GONE  = 2'd2,
        MARK_SPARE = 2'd3
    } t_mark;

endpackage

[sv/dhoat_if.sv]
// ----------------------------------------------------------------------------
// dhoat_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface dhoat_if #(
    parameter int W = 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/double_hash_open_address_table.sv]
// ----------------------------------------------------------------------------
// double_hash_open_address_table
// Open-addressing hash table with double hashing over a slot memory.
// ----------------------------------------------------------------------------
//  channel   dir   payload                  transfer when
//  in_ch     in    command, key             valid & ready
//  out_ch    out   slot, outcome            valid & ready
//  cfg_ch    in    table_size (11 bits)     valid & ready
//
//  After reset a sweep clears all TABLE_DEPTH marks, one per cycle; no item
//  is taken meanwhile. An item then takes two remainder passes through the
//  bit-serial remainder unit, then per probe a memory read and a check, then
//  a write (insert into a free slot, or remove hit) and a hand-off.
//  The result register holds while out_ch stalls; the next item is taken
//  only once the result has transferred.
// ----------------------------------------------------------------------------
module double_hash_open_address_table
    import dhoat_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_BITS    = 31
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    dhoat_if.sink   in_ch,
    dhoat_if.source out_ch,
    dhoat_if.sink   cfg_ch
);
    localparam int IDX_BITS = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int M_BITS   = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_H1    = 8'b0000_0100,
        S_H2    = 8'b0000_1000,
        S_READ  = 8'b0001_0000,
        S_CHECK = 8'b0010_0000,
        S_WRITE = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state               r_state, n_state;
    logic [CFG_BITS-1:0]  r_size;
    logic [M_BITS-1:0]    r_m;
    t_cmd                 r_cmd;
    logic [KEY_BITS-1:0]  r_key;
    logic [M_BITS-1:0]    r_h2;
    logic [M_BITS-1:0]    r_pos;
    logic [M_BITS-1:0]    r_cnt;
    logic [IDX_BITS-1:0]  r_clr;
    logic [SLOT_BITS-1:0] r_slot;
    logic                 r_fail;
    logic                 r_wr_used;

    logic                 w_mod_start, w_mod_done;
    logic [KEY_BITS-1:0]  w_mod_num;
    logic [M_BITS-1:0]    w_mod_den, w_mod_rem;
    logic [KEY_BITS-1:0]  w_rkey;
    t_mark                w_rmark;
    logic                 w_kwe, w_mwe;
    logic [IDX_BITS-1:0]  w_raddr, w_waddr;
    t_mark                w_wmark;
    logic [M_BITS:0]      w_next_sum;
    logic [M_BITS-1:0]    w_next_pos;
    logic [M_BITS-1:0]    w_m_eff;

    // clamp the configured size to [2, TABLE_DEPTH]
    always_comb begin
        if (r_size < CFG_BITS'(2)) begin
            w_m_eff = M_BITS'(2);
        end else if (32'(r_size) > TABLE_DEPTH) begin
            w_m_eff = M_BITS'(TABLE_DEPTH);
        end else begin
            w_m_eff = M_BITS'(r_size);
        end
    end

    assign in_ch.ready  = (r_state == S_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = (r_state == S_OUT);
    assign out_ch.data  = {r_slot, r_fail};

    // both remainders share one bit-serial unit
    assign w_mod_start = (r_state == S_IDLE && in_ch.valid) ||
                         (r_state == S_H1 && w_mod_done);
    assign w_mod_num   = (r_state == S_IDLE) ? in_ch.data[KEY_BITS-1:0] : r_key;
    assign w_mod_den   = (r_state == S_IDLE) ? w_m_eff : M_BITS'(r_m - 1'b1);

    dhoat_mod #(.NUM_BITS(KEY_BITS), .DEN_BITS(M_BITS)) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_num   (w_mod_num),
        .i_den   (w_mod_den),
        .o_done  (w_mod_done),
        .o_rem   (w_mod_rem)
    );

    // next probe: (pos + h2) mod m, both below m so one subtract suffices
    assign w_next_sum = {1'b0, r_pos} + {1'b0, r_h2};
    assign w_next_pos = (w_next_sum >= {1'b0, r_m}) ?
                        M_BITS'(w_next_sum - {1'b0, r_m}) : M_BITS'(w_next_sum);

    assign w_raddr = r_pos[IDX_BITS-1:0];
    assign w_waddr = (r_state == S_CLEAR) ? r_clr : r_pos[IDX_BITS-1:0];
    assign w_mwe   = (r_state == S_CLEAR) || (r_state == S_WRITE);
    assign w_kwe   = (r_state == S_WRITE) && r_wr_used;
    assign w_wmark = (r_state == S_CLEAR) ? MARK_EMPTY :
                     (r_wr_used ? MARK_USED : MARK_GONE);

    dhoat_store #(
        .TABLE_DEPTH(TABLE_DEPTH), .KEY_BITS(KEY_BITS), .IDX_BITS(IDX_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_raddr (w_raddr),
        .o_rkey  (w_rkey),
        .o_rmark (w_rmark),
        .i_kwe   (w_kwe),
        .i_mwe   (w_mwe),
        .i_waddr (w_waddr),
        .i_wkey  (r_key),
        .i_wmark (w_wmark)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (32'(r_clr) == TABLE_DEPTH - 1) n_state = S_IDLE;
            S_IDLE:  if (in_ch.valid) n_state = S_H1;
            S_H1:    if (w_mod_done) n_state = S_H2;
            S_H2:    if (w_mod_done) n_state = S_READ;
            S_READ:  n_state = S_CHECK;
            S_CHECK: begin
                if (r_cmd == CMD_INSERT) begin
                    if (w_rmark != MARK_USED) n_state = S_WRITE;
                    else if (r_cnt == r_m - 1'b1) n_state = S_OUT;
                    else n_state = S_READ;
                end else begin
                    if (w_rmark == MARK_EMPTY) n_state = S_OUT;
                    else if (w_rmark == MARK_USED && w_rkey == r_key) begin
                        n_state = (r_cmd == CMD_REMOVE) ? S_WRITE : S_OUT;
                    end else if (r_cnt == r_m - 1'b1) n_state = S_OUT;
                    else n_state = S_READ;
                end
            end
            S_WRITE: n_state = S_OUT;
            S_OUT:   if (out_ch.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_size  <= CFG_BITS'(1024);
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (cfg_ch.valid) r_size <= cfg_ch.data;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_cmd  <= t_cmd'(in_ch.data[KEY_BITS+CMD_BITS-1:KEY_BITS]);
                r_key  <= in_ch.data[KEY_BITS-1:0];
                r_m    <= w_m_eff;
                r_slot <= '0;
                r_fail <= 1'b1;
            end
            S_H1: if (w_mod_done) r_pos <= w_mod_rem;
            S_H2: begin
                if (w_mod_done) begin
                    r_h2  <= M_BITS'(w_mod_rem + 1'b1);
                    // command 3: stops after the first probe, answers failure
                    r_cnt <= (r_cmd == CMD_NONE) ? M_BITS'(r_m - 1'b1) : '0;
                end
            end
            S_CHECK: begin
                r_wr_used <= (r_cmd == CMD_INSERT);
                if (r_cmd == CMD_NONE) begin
                    r_fail <= 1'b1;
                end else if ((r_cmd == CMD_INSERT && w_rmark != MARK_USED) ||
                    (r_cmd != CMD_INSERT && w_rmark == MARK_USED && w_rkey == r_key)) begin
                    r_slot <= SLOT_BITS'(r_pos);
                    r_fail <= 1'b0;
                end
                // hold the probe position when the slot is to be written
                if (n_state == S_READ) begin
                    r_pos <= w_next_pos;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            default: ;
        endcase
    end
endmodule

[sv/dhoat_mod.sv]
// ----------------------------------------------------------------------------
// dhoat_mod
// Iterative restoring remainder unit: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dhoat_mod #(
    parameter int NUM_BITS = 31,
    parameter int DEN_BITS = 17
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic                o_done,
    output logic [DEN_BITS-1:0] o_rem
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] r_num;
    logic [DEN_BITS-1:0] r_den;
    logic [DEN_BITS:0]   r_rem;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [DEN_BITS+1:0] w_shift;

    // shift in the next numerator bit, subtract when it fits
    assign w_shift = {r_rem, r_num[NUM_BITS-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // pulse on the last quotient bit
            r_done <= r_busy && !i_start && (r_cnt == CNT_BITS'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(NUM_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_BITS-2:0], 1'b0};
            if (w_shift >= {2'b00, r_den}) begin
                r_rem <= (DEN_BITS+1)'(w_shift - {2'b00, r_den});
            end else begin
                r_rem <= w_shift[DEN_BITS:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[DEN_BITS-1:0];
endmodule

[sv/dhoat_store.sv]
// ----------------------------------------------------------------------------
// dhoat_store
// Slot key and mark memories with registered reads; marks cleared by a sweep.
// ----------------------------------------------------------------------------
module dhoat_store
    import dhoat_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_BITS    = 31,
    parameter int IDX_BITS    = 10
) (
    input  logic                i_clk,
    input  logic [IDX_BITS-1:0] i_raddr,
    output logic [KEY_BITS-1:0] o_rkey,
    output t_mark               o_rmark,
    input  logic                i_kwe,
    input  logic                i_mwe,
    input  logic [IDX_BITS-1:0] i_waddr,
    input  logic [KEY_BITS-1:0] i_wkey,
    input  t_mark               i_wmark
);
    logic [KEY_BITS-1:0] r_keys  [TABLE_DEPTH];
    t_mark               r_marks [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_kwe) begin
            r_keys[i_waddr] <= i_wkey;
        end
        o_rkey <= r_keys[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_mwe) begin
            r_marks[i_waddr] <= i_wmark;
        end
        o_rmark <= r_marks[i_raddr];
    end
endmodule
